[rtl/bbpe_pkg.sv]
// Shared types, widths and a helper function of the bicubic Bezier patch evaluator.
package bbpe_pkg;

	// Field widths of the request and response.
	localparam int PATCHES_DEF = 32;
	localparam int COORD_BITS  = 16;
	localparam int PATCH_IDX_W = 5;
	localparam int POINT_IDX_W = 4;
	localparam int PARAM_W     = 16;

	// Control points per patch, row * 4 + column.
	localparam int PTS_PER_PATCH = 16;

	// Datapath widths. A Bernstein weight is Q1.16 and may reach exactly one.
	localparam int WGT_W      = PARAM_W + 1;
	localparam int SQ_W       = 2 * PARAM_W + 1;
	localparam int FRAC_SHIFT = 2 * PARAM_W;
	localparam int ROW_W      = COORD_BITS + WGT_W;
	localparam int A_W        = (ROW_W > SQ_W + 1) ? ROW_W : SQ_W + 1;
	localparam int B_W        = PARAM_W + 3;
	localparam int P_W        = A_W + B_W;
	localparam int TOT_W      = COORD_BITS + FRAC_SHIFT + 2;
	localparam int SH_W       = TOT_W - FRAC_SHIFT;

	// Saturation bounds at the width of the shifted total.
	localparam logic signed [SH_W-1:0] SAT_HI = {3'b000, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [SH_W-1:0] SAT_LO = {3'b111, {(COORD_BITS - 1){1'b0}}};

	// Request function codes.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	typedef struct packed {
		logic                         func;
		logic [PATCH_IDX_W-1:0]       patch_index;
		logic [POINT_IDX_W-1:0]       point_index;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
		logic [PARAM_W-1:0]           u_param;
		logic [PARAM_W-1:0]           v_param;
	} req_t;

	typedef struct packed {
		logic [PATCH_IDX_W-1:0]       patch_out;
		logic signed [COORD_BITS-1:0] surf_x;
		logic signed [COORD_BITS-1:0] surf_y;
		logic signed [COORD_BITS-1:0] surf_z;
	} rsp_t;

	// Floor the Q9.40 total to eight fraction bits and clamp it to the Q7.8 coordinate range.
	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [TOT_W-1:0] x
	);
		logic signed [SH_W-1:0] sh;
		sh = x[TOT_W-1:FRAC_SHIFT];
		if (sh > SAT_HI) begin
			return SAT_HI[COORD_BITS-1:0];
		end else if (sh < SAT_LO) begin
			return SAT_LO[COORD_BITS-1:0];
		end
		return sh[COORD_BITS-1:0];
	endfunction

endpackage

[rtl/bbpe_mul.sv]
// Shared signed multiplier with a registered product.
module bbpe_mul import bbpe_pkg::*; (
	input  logic                  clk,
	input  logic signed [A_W-1:0] a,
	input  logic signed [B_W-1:0] b,
	output logic signed [P_W-1:0] p
);

	// One product per cycle, available the cycle after its operands.
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

[rtl/bicubic_bezier_patch_eval_top.sv]
// Top level of the bicubic Bezier patch evaluator: point store, sequencer and datapath.
//
// The block stores sixteen control points (x, y, z in signed Q7.8) for each of PATCHES
// patches and evaluates surface points at parameters u and v (unsigned Q0.16). A load
// request writes one point and returns nothing, and the block stays ready. An evaluate
// request runs on one shared multiplier: twelve products form the eight Bernstein
// weights, then each coordinate takes four rows of four point products plus one row
// weighting, with a gap slot before each row weighting while the row sum settles.
// After the multiplier pipeline drains, the response is registered and the block
// returns to ready for the next request; a stalled response consumer holds the block
// in its finish step until the previous response is taken. An evaluate of a patch at
// or above PATCHES answers zeros from the finish step without running the datapath,
// and a load of such a patch is dropped. The point store has no reset: reading a point
// that was never loaded gives an undefined result.
module bicubic_bezier_patch_eval_top import bbpe_pkg::*; #(
	parameter int PATCHES = PATCHES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	localparam int DEPTH   = PATCHES * PTS_PER_PATCH;
	localparam int PATCH_W = (PATCHES > 1) ? $clog2(PATCHES) : 1;
	localparam int ADDR_W  = PATCH_W + POINT_IDX_W;
	localparam int WORD_W  = 3 * COORD_BITS;

	// Sequencer limits.
	localparam logic [3:0] SQ_STEPS   = 4'd4;
	localparam logic [3:0] LAST_WSTEP = 4'd11;
	localparam logic [2:0] SLOT_GAP   = 3'd4;
	localparam logic [2:0] SLOT_VM    = 3'd5;
	localparam logic [1:0] LAST_ROW   = 2'd3;
	localparam logic [1:0] LAST_COORD = 2'd2;
	localparam logic [1:0] COORD_X    = 2'd0;
	localparam logic [1:0] COORD_Y    = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WGT,
		ST_PTS,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_SQ,
		OP_WT,
		OP_PT,
		OP_VM
	} op_kind_t;

	// One slot of work for the shared multiplier.
	typedef struct packed {
		op_kind_t   kind;
		logic       uv;
		logic [1:0] sel;
		logic [1:0] row;
		logic [1:0] col;
		logic [1:0] coord;
	} op_t;

	state_t state_q;
	logic [3:0] wstep_q;
	logic [1:0] coord_q;
	logic [1:0] row_q;
	logic [2:0] slot_q;
	logic       drain_q;
	logic       rsp_valid_q;
	rsp_t       rsp_data_q;

	logic [PATCH_IDX_W-1:0]       patch_q;
	logic [PARAM_W-1:0]           t_q [2];
	logic [SQ_W-1:0]              sq_q [2][2];
	logic [WGT_W-1:0]             wgt_q [2][4];
	logic signed [ROW_W-1:0]      row_acc_q;
	logic signed [TOT_W-1:0]      tot_q;
	logic signed [COORD_BITS-1:0] res_q [3];

	logic [WORD_W-1:0] cp_mem [DEPTH];
	logic [WORD_W-1:0] rdata_s1;

	op_t op_s0;
	op_t op_s1;
	op_t op_s2;

	logic signed [A_W-1:0] mul_a;
	logic signed [B_W-1:0] mul_b;
	logic signed [P_W-1:0] prod_s2;

	logic req_acc;
	logic patch_ok;
	logic load_we;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [3:0] wstep_off;

	logic [PARAM_W-1:0]           t_sel;
	logic [WGT_W-1:0]             s_sel;
	logic [WGT_W:0]               t3_sel;
	logic [WGT_W:0]               s3_sel;
	logic signed [COORD_BITS-1:0] pt_coord;
	logic signed [ROW_W-1:0]      row_sum;
	logic signed [TOT_W-1:0]      tot_sum;

	// Request handshake and decode.
	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign patch_ok  = int'(req_data.patch_index) < PATCHES;
	assign load_we   = req_acc && (req_data.func == FUNC_LOAD) && patch_ok;
	assign wr_addr   = {PATCH_W'(req_data.patch_index), req_data.point_index};
	assign rd_addr   = {PATCH_W'(patch_q), row_q, slot_q[1:0]};

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wstep_q     <= '0;
			coord_q     <= '0;
			row_q       <= '0;
			slot_q      <= '0;
			drain_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The finish step decides the response valid on its own.
			if (rsp_ready && (state_q != ST_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && (req_data.func == FUNC_EVAL)) begin
						wstep_q <= '0;
						state_q <= patch_ok ? ST_WGT : ST_FINISH;
					end
				end
				ST_WGT: begin
					if (wstep_q == LAST_WSTEP) begin
						coord_q <= '0;
						row_q   <= '0;
						slot_q  <= '0;
						state_q <= ST_PTS;
					end else begin
						wstep_q <= wstep_q + 4'd1;
					end
				end
				ST_PTS: begin
					if (slot_q == SLOT_VM) begin
						slot_q <= '0;
						if (row_q == LAST_ROW) begin
							row_q <= '0;
							if (coord_q == LAST_COORD) begin
								drain_q <= 1'b0;
								state_q <= ST_DRAIN;
							end else begin
								coord_q <= coord_q + 2'd1;
							end
						end else begin
							row_q <= row_q + 2'd1;
						end
					end else begin
						slot_q <= slot_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					if (drain_q) begin
						state_q <= ST_FINISH;
					end else begin
						drain_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_data_q.patch_out <= patch_q;
						rsp_data_q.surf_x    <= res_q[0];
						rsp_data_q.surf_y    <= res_q[1];
						rsp_data_q.surf_z    <= res_q[2];
						rsp_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Slot issue: what the multiplier does for the current sequencer position.
	assign wstep_off = wstep_q - SQ_STEPS;

	always_comb begin
		op_s0       = '0;
		op_s0.kind  = OP_NOP;
		op_s0.row   = row_q;
		op_s0.col   = slot_q[1:0];
		op_s0.coord = coord_q;
		op_s0.uv    = wstep_q[0];
		case (state_q)
			ST_WGT: begin
				if (wstep_q < SQ_STEPS) begin
					op_s0.kind = OP_SQ;
					op_s0.sel  = {1'b0, wstep_q[1]};
				end else begin
					op_s0.kind = OP_WT;
					op_s0.sel  = wstep_off[2:1];
				end
			end
			ST_PTS: begin
				if (slot_q == SLOT_VM) begin
					op_s0.kind = OP_VM;
				end else if (slot_q != SLOT_GAP) begin
					op_s0.kind = OP_PT;
				end
			end
			default: begin
				op_s0.kind = OP_NOP;
			end
		endcase
	end

	// Slot pipeline: issue, operand select and multiply, write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
		end else begin
			op_s1 <= op_s0;
			op_s2 <= op_s1;
		end
	end

	// Control point store; the read feeds the operand stage.
	always_ff @(posedge clk) begin
		if (load_we) begin
			cp_mem[wr_addr] <= {req_data.point_z, req_data.point_y, req_data.point_x};
		end
		rdata_s1 <= cp_mem[rd_addr];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		t_sel  = t_q[op_s1.uv];
		s_sel  = WGT_W'(1 << PARAM_W) - {1'b0, t_sel};
		t3_sel = {2'b00, t_sel} + {1'b0, t_sel, 1'b0};
		s3_sel = {1'b0, s_sel} + {s_sel, 1'b0};
		case (op_s1.coord)
			COORD_X: pt_coord = rdata_s1[COORD_BITS-1:0];
			COORD_Y: pt_coord = rdata_s1[2*COORD_BITS-1:COORD_BITS];
			default: pt_coord = rdata_s1[3*COORD_BITS-1:2*COORD_BITS];
		endcase
		mul_a = '0;
		mul_b = '0;
		case (op_s1.kind)
			OP_SQ: begin
				if (op_s1.sel[0]) begin
					mul_a = signed'(A_W'(t_sel));
					mul_b = signed'(B_W'(t_sel));
				end else begin
					mul_a = signed'(A_W'(s_sel));
					mul_b = signed'(B_W'(s_sel));
				end
			end
			OP_WT: begin
				mul_a = signed'(A_W'(sq_q[op_s1.uv][op_s1.sel[1]]));
				case (op_s1.sel)
					2'd0:    mul_b = signed'(B_W'(s_sel));
					2'd1:    mul_b = signed'(B_W'(t3_sel));
					2'd2:    mul_b = signed'(B_W'(s3_sel));
					default: mul_b = signed'(B_W'(t_sel));
				endcase
			end
			OP_PT: begin
				mul_a = A_W'(pt_coord);
				mul_b = signed'(B_W'(wgt_q[0][op_s1.col]));
			end
			OP_VM: begin
				mul_a = A_W'(row_acc_q);
				mul_b = signed'(B_W'(wgt_q[1][op_s1.row]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	bbpe_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod_s2)
	);

	// Row and total accumulation; the first term of each sum starts from zero.
	always_comb begin
		row_sum = ((op_s2.col == 2'd0) ? ROW_W'(0) : row_acc_q) + $signed(prod_s2[ROW_W-1:0]);
		tot_sum = ((op_s2.row == 2'd0) ? TOT_W'(0) : tot_q) + $signed(prod_s2[TOT_W-1:0]);
	end

	// Datapath registers: request capture and write back of each product.
	always_ff @(posedge clk) begin
		if (req_acc && (req_data.func == FUNC_EVAL)) begin
			patch_q <= req_data.patch_index;
			t_q[0]  <= req_data.u_param;
			t_q[1]  <= req_data.v_param;
			if (!patch_ok) begin
				res_q[0] <= '0;
				res_q[1] <= '0;
				res_q[2] <= '0;
			end
		end
		case (op_s2.kind)
			OP_SQ: begin
				sq_q[op_s2.uv][op_s2.sel[0]] <= prod_s2[SQ_W-1:0];
			end
			OP_WT: begin
				wgt_q[op_s2.uv][op_s2.sel] <= prod_s2[FRAC_SHIFT +: WGT_W];
			end
			OP_PT: begin
				row_acc_q <= row_sum;
			end
			OP_VM: begin
				tot_q <= tot_sum;
				if (op_s2.row == LAST_ROW) begin
					res_q[op_s2.coord] <= sat_coord(tot_sum);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/bbpe_checker.sv]
// Port-level assertions for the bicubic Bezier patch evaluator, bound to the top level.
module bbpe_checker import bbpe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// A stalled response holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// An evaluate request occupies the block for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.func == FUNC_EVAL) |=> !req_ready)
		else $error("ready stayed high after an evaluate request");

	// A load request completes at once and leaves the block ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.func == FUNC_LOAD) |=> req_ready)
		else $error("ready dropped after a load request");

	// A new response appears only as the block returns to ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("response raised while still busy");

endmodule

bind bicubic_bezier_patch_eval_top bbpe_checker u_bbpe_checker (.*);

[bench/bicubic_bezier_patch_eval_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the bicubic Bezier patch evaluator with its own surface predictor.
module bicubic_bezier_patch_eval_top_test;
	import bbpe_pkg::*;

	localparam int PATCHES = PATCHES_DEF;
	localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;
	localparam logic [COORD_BITS-1:0] COORD_MAX = COORD_HI[COORD_BITS-1:0];
	localparam logic [COORD_BITS-1:0] COORD_MIN = COORD_LO[COORD_BITS-1:0];
	localparam logic [PARAM_W-1:0] PARAM_MAX = '1;
	localparam logic [PARAM_W-1:0] PARAM_HALF = PARAM_W'(1 << (PARAM_W - 1));
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 40;
	localparam int HOLD_CYCLES = 600;

	typedef logic [3:0][WGT_W-1:0] weight_set_t;
	typedef logic [PTS_PER_PATCH-1:0][COORD_BITS-1:0] patch_coords_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	// Predictor state: the control points as the block should hold them.
	patch_coords_t store_x [PATCHES];
	patch_coords_t store_y [PATCHES];
	patch_coords_t store_z [PATCHES];
	rsp_t pending_points [$];
	rsp_t oldest_point;
	int error_count = 0;

	// Stimulus side: which points have been loaded, so no unwritten point is read.
	logic [PTS_PER_PATCH-1:0] loaded_mask [PATCHES];
	int filled_count = 0;

	// Idling controls shared by the tests and the response side.
	bit req_idle_on = 1'b1;
	bit rsp_idle_on = 1'b1;
	int rsp_hold_len = 0;
	int hold_left = 0;
	int stretch_left = 0;
	logic ready_level = 1'b1;
	int idle_cycles = 0;

	bicubic_bezier_patch_eval_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bernstein weights of t in Q0.16, each formed exactly and floored to Q1.16.
	function automatic weight_set_t bernstein_weights(input logic [PARAM_W-1:0] t);
		longint unsigned tu;
		longint unsigned su;
		weight_set_t w;
		tu = t;
		su = (64'd1 << PARAM_W) - tu;
		w[0] = WGT_W'((su * su * su) >> FRAC_SHIFT);
		w[1] = WGT_W'((64'd3 * tu * su * su) >> FRAC_SHIFT);
		w[2] = WGT_W'((64'd3 * tu * tu * su) >> FRAC_SHIFT);
		w[3] = WGT_W'((tu * tu * tu) >> FRAC_SHIFT);
		return w;
	endfunction

	// One coordinate of the surface point: u weights columns, v weights rows.
	function automatic logic [COORD_BITS-1:0] blend_coord(input patch_coords_t pts,
			input weight_set_t wu, input weight_set_t wv);
		longint total;
		longint row_sum;
		total = 0;
		for (int r = 0; r < 4; r++) begin
			row_sum = 0;
			for (int c = 0; c < 4; c++) begin
				row_sum += longint'(wu[c]) * longint'($signed(pts[r * 4 + c]));
			end
			total += longint'(wv[r]) * row_sum;
		end
		total = total >>> FRAC_SHIFT;
		if (total > COORD_HI) begin
			total = COORD_HI;
		end else if (total < COORD_LO) begin
			total = COORD_LO;
		end
		return total[COORD_BITS-1:0];
	endfunction

	// Expected response of one evaluate request against the current point store.
	function automatic rsp_t bezier_surface_point(input req_t r);
		rsp_t p;
		weight_set_t wu;
		weight_set_t wv;
		p = '0;
		p.patch_out = r.patch_index;
		if (r.patch_index < PATCHES) begin
			wu = bernstein_weights(r.u_param);
			wv = bernstein_weights(r.v_param);
			p.surf_x = blend_coord(store_x[r.patch_index], wu, wv);
			p.surf_y = blend_coord(store_y[r.patch_index], wu, wv);
			p.surf_z = blend_coord(store_z[r.patch_index], wu, wv);
		end
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_REPORTS) begin
			$display("%0t mismatch: %s", $realtime, msg);
		end
		error_count++;
	endtask

	// Track accepted requests in the predictor and check each accepted response.
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			if (req_data.func == FUNC_LOAD) begin
				if (req_data.patch_index < PATCHES) begin
					store_x[req_data.patch_index][req_data.point_index] = req_data.point_x;
					store_y[req_data.patch_index][req_data.point_index] = req_data.point_y;
					store_z[req_data.patch_index][req_data.point_index] = req_data.point_z;
				end
			end else begin
				pending_points.push_back(bezier_surface_point(req_data));
			end
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("response for patch %0d with none expected",
					rsp_data.patch_out));
			end else begin
				oldest_point = pending_points.pop_front();
				if (rsp_data.patch_out !== oldest_point.patch_out)
					report_mismatch($sformatf("patch_out got %0d expected %0d",
						rsp_data.patch_out, oldest_point.patch_out));
				if (rsp_data.surf_x !== oldest_point.surf_x)
					report_mismatch($sformatf("patch %0d surf_x got %0d expected %0d",
						oldest_point.patch_out, rsp_data.surf_x, oldest_point.surf_x));
				if (rsp_data.surf_y !== oldest_point.surf_y)
					report_mismatch($sformatf("patch %0d surf_y got %0d expected %0d",
						oldest_point.patch_out, rsp_data.surf_y, oldest_point.surf_y));
				if (rsp_data.surf_z !== oldest_point.surf_z)
					report_mismatch($sformatf("patch %0d surf_z got %0d expected %0d",
						oldest_point.patch_out, rsp_data.surf_z, oldest_point.surf_z));
			end
		end
	end

	// Response side: a requested long hold, else random ready and stall stretches when idling.
	always @(posedge clk) begin
		if (rsp_hold_len > 0) begin
			hold_left = rsp_hold_len;
			rsp_hold_len = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (!rsp_idle_on) begin
			rsp_ready <= 1'b1;
		end else begin
			if (stretch_left == 0) begin
				ready_level = 1'($urandom_range(0, 1));
				if (ready_level) begin
					stretch_left = $urandom_range(1, 20);
				end else if ($urandom_range(0, 9) == 0) begin
					stretch_left = $urandom_range(20, 150);
				end else begin
					stretch_left = $urandom_range(1, 3);
				end
			end
			stretch_left--;
			rsp_ready <= ready_level;
		end
	end

	// Watchdog on cycles in which neither channel moves a request or a response.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!req_idle_on || roll < 70) begin
			return 0;
		end else if (roll < 95) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return COORD_BITS'($urandom_range(0, 511) - 256);
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [PARAM_W-1:0] pick_param();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return PARAM_MAX;
			2: return PARAM_HALF;
			default: return PARAM_W'($urandom);
		endcase
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	task automatic send_request(input req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	// Stop offering requests until every expected surface point has come back.
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_points.size() != 0);
	endtask

	task automatic load_point(input int patch, input int idx,
			input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input logic [COORD_BITS-1:0] z);
		req_t r;
		r.func = FUNC_LOAD;
		r.patch_index = PATCH_IDX_W'(patch);
		r.point_index = POINT_IDX_W'(idx);
		r.point_x = x;
		r.point_y = y;
		r.point_z = z;
		r.u_param = PARAM_W'($urandom);
		r.v_param = PARAM_W'($urandom);
		if (!(&loaded_mask[patch])) begin
			loaded_mask[patch][idx] = 1'b1;
			if (&loaded_mask[patch]) filled_count++;
		end
		send_request(r);
	endtask

	task automatic evaluate_point(input int patch, input logic [PARAM_W-1:0] u,
			input logic [PARAM_W-1:0] v);
		req_t r;
		r.func = FUNC_EVAL;
		r.patch_index = PATCH_IDX_W'(patch);
		r.point_index = POINT_IDX_W'($urandom);
		r.point_x = COORD_BITS'($urandom);
		r.point_y = COORD_BITS'($urandom);
		r.point_z = COORD_BITS'($urandom);
		r.u_param = u;
		r.v_param = v;
		send_request(r);
	endtask

	// Load all sixteen points of a patch in a shuffled order.
	task automatic fill_patch(input int patch);
		int order [PTS_PER_PATCH];
		int j;
		int tmp;
		for (int i = 0; i < PTS_PER_PATCH; i++) order[i] = i;
		for (int i = PTS_PER_PATCH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < PTS_PER_PATCH; i++) begin
			load_point(patch, order[i], pick_coord(), pick_coord(), pick_coord());
		end
	endtask

	function automatic int pick_filled_patch();
		int p;
		do p = $urandom_range(0, PATCHES - 1); while (!(&loaded_mask[p]));
		return p;
	endfunction

	// Mostly well-formed traffic: whole patches loaded, then evaluated at random u, v.
	task automatic run_patch_traffic(input int count);
		int sent;
		int roll;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(0, 99);
			if (filled_count == 0 || roll < 15) begin
				fill_patch($urandom_range(0, PATCHES - 1));
				sent += PTS_PER_PATCH;
			end else if (roll < 40) begin
				load_point($urandom_range(0, PATCHES - 1), $urandom_range(0, PTS_PER_PATCH - 1),
					pick_coord(), pick_coord(), pick_coord());
				sent++;
			end else if (roll < 98) begin
				evaluate_point(pick_filled_patch(), pick_param(), pick_param());
				sent++;
			end else begin
				wait_results_drained();
			end
		end
	endtask

	// Coordinate extremes on patch 0 at the parameter corners and center, then a quarter point.
	task automatic test_corner_points();
		for (int i = 0; i < PTS_PER_PATCH; i++) begin
			load_point(0, i, COORD_MAX, COORD_MIN, (i % 2) ? COORD_MIN : COORD_MAX);
		end
		evaluate_point(0, '0, '0);
		evaluate_point(0, PARAM_MAX, '0);
		evaluate_point(0, '0, PARAM_MAX);
		evaluate_point(0, PARAM_MAX, PARAM_MAX);
		evaluate_point(0, PARAM_HALF, PARAM_HALF);
		load_point(0, 5, COORD_MIN, COORD_MAX, '0);
		evaluate_point(0, PARAM_HALF >> 1, PARAM_HALF >> 1);
	endtask

	task automatic test_mixed_traffic(input int count);
		req_idle_on = 1'b1;
		rsp_idle_on = 1'b1;
		if (!(&loaded_mask[PATCHES - 1])) fill_patch(PATCHES - 1);
		run_patch_traffic(count);
	endtask

	task automatic test_full_rate(input int count);
		req_idle_on = 1'b0;
		rsp_idle_on = 1'b0;
		run_patch_traffic(count);
		req_idle_on = 1'b1;
		rsp_idle_on = 1'b1;
	endtask

	// Hold the response side off while requests keep coming, so the input stalls.
	task automatic test_response_hold();
		req_idle_on = 1'b0;
		wait_results_drained();
		rsp_hold_len = HOLD_CYCLES;
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 2) begin
				load_point($urandom_range(0, PATCHES - 1), $urandom_range(0, PTS_PER_PATCH - 1),
					pick_coord(), pick_coord(), pick_coord());
			end else begin
				evaluate_point(pick_filled_patch(), pick_param(), pick_param());
			end
		end
		wait_results_drained();
		req_idle_on = 1'b1;
	endtask

	initial begin
		for (int p = 0; p < PATCHES; p++) begin
			loaded_mask[p] = '0;
			store_x[p] = '0;
			store_y[p] = '0;
			store_z[p] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_points();
		test_mixed_traffic(700);
		test_response_hold();
		test_full_rate(300);
		test_mixed_traffic(400);
		wait_results_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
